FILE: design/ppm_pkg.sv
// Shared widths, codes and reset values for the pulse period meter.
`default_nettype none
package ppm_pkg;

  localparam int MaskWidth    = 10;
  localparam int ChanWidth    = 4;
  localparam int TsWidth      = 32;
  localparam int PeriodWidth  = 40;
  localparam int CountWidth   = 32;
  localparam int NsWidth      = 8;
  localparam int CfgIdxWidth  = 1;
  localparam int CfgDataWidth = 8;

  // Channels kept in narrow mode, counted from the top.
  localparam int NarrowChannels = 5;

  localparam logic CmdEdge     = 1'b0;
  localparam logic CmdOverflow = 1'b1;

  localparam logic [CfgIdxWidth-1:0] RegAllChannels = 1'd0;
  localparam logic [CfgIdxWidth-1:0] RegNsPerTick   = 1'd1;

  localparam logic               AllChannelsReset = 1'b1;
  localparam logic [NsWidth-1:0] NsPerTickReset   = 8'd50;

endpackage
`default_nettype wire

FILE: design/ppm_if.sv
// Request and response channel interfaces of the pulse period meter.
`default_nettype none
interface ppm_req_if;
  logic                            valid;
  logic                            ready;
  logic                            command;
  logic [ppm_pkg::MaskWidth-1:0]   edge_mask;
  logic [ppm_pkg::TsWidth-1:0]     timestamp;

  modport source (output valid, output command, output edge_mask, output timestamp,
                  input ready);
  modport sink   (input valid, input command, input edge_mask, input timestamp,
                  output ready);
endinterface

interface ppm_rsp_if;
  logic                            valid;
  logic                            ready;
  logic                            channel_valid;
  logic [ppm_pkg::ChanWidth-1:0]   channel;
  logic [ppm_pkg::PeriodWidth-1:0] period_ns;
  logic [ppm_pkg::CountWidth-1:0]  channel_hits;
  logic [ppm_pkg::CountWidth-1:0]  global_hits;
  logic [ppm_pkg::CountWidth-1:0]  overflow_count;
  logic                            last;

  modport source (output valid, output channel_valid, output channel, output period_ns,
                  output channel_hits, output global_hits, output overflow_count,
                  output last, input ready);
  modport sink   (input valid, input channel_valid, input channel, input period_ns,
                  input channel_hits, input global_hits, input overflow_count,
                  input last, output ready);
endinterface
`default_nettype wire

FILE: design/multichannel_pulse_period_meter.sv
// Top level: multichannel pulse period meter with a shared subtract/multiply sequencer.
//
//   channel  | direction | carries
//   ---------+-----------+------------------------------------------------------
//   req_i    | in        | edge event (mask + timestamp) or timer overflow tick
//   rsp_o    | out       | one result per serviced channel, or one status result
//   cfg_*    | in        | register writes: all_channels, ns_per_tick
//
// An overflow tick or an event that services no channel goes from accept
// straight to the result register. An event servicing k channels steps, per
// channel, through the stamp subtractor, the period multiplier and the output
// register with the result.
// A stalled rsp_o holds the sequencer in the output state; req_i.ready is
// high only when no request is in progress. Reset clears all per-channel stamps and counters.
`default_nettype none
module multichannel_pulse_period_meter #(
  parameter int NUM_CHANNELS = 10,
  parameter int STAMP_WIDTH  = 32
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [ppm_pkg::CfgIdxWidth-1:0]   cfg_idx_i,
  input  wire logic [ppm_pkg::CfgDataWidth-1:0]  cfg_data_i,
  ppm_req_if.sink                                req_i,
  ppm_rsp_if.source                              rsp_o
);

  // Channels that a mask bit can reach.
  localparam int SvcCh  = (NUM_CHANNELS < ppm_pkg::MaskWidth) ? NUM_CHANNELS
                                                              : ppm_pkg::MaskWidth;
  localparam int IdxW   = (SvcCh > 1) ? $clog2(SvcCh) : 1;
  localparam int Lowest = (NUM_CHANNELS > ppm_pkg::NarrowChannels)
                          ? NUM_CHANNELS - ppm_pkg::NarrowChannels : 0;
  localparam int ProdW  = STAMP_WIDTH + ppm_pkg::NsWidth;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiff = 2'd1;
  localparam logic [1:0] StMul  = 2'd2;
  localparam logic [1:0] StOut  = 2'd3;

  logic [1:0]                        state_q, state_d;
  logic                              all_ch_q;
  logic [ppm_pkg::NsWidth-1:0]       ns_q;
  logic [SvcCh-1:0]                  pend_q;
  logic [STAMP_WIDTH-1:0]            stamp_q;
  logic [STAMP_WIDTH-1:0]            stamp_mem_q [SvcCh];
  logic [ppm_pkg::CountWidth-1:0]    hits_mem_q  [SvcCh];
  logic [ppm_pkg::CountWidth-1:0]    total_q;
  logic [ppm_pkg::CountWidth-1:0]    ovf_q;
  logic [IdxW-1:0]                   idx_q;
  logic [STAMP_WIDTH-1:0]            diff_q;
  logic [ppm_pkg::CountWidth-1:0]    hits_q;
  logic                              out_cv_q;
  logic [ppm_pkg::ChanWidth-1:0]     out_chan_q;
  logic [ppm_pkg::PeriodWidth-1:0]   out_per_q;
  logic [ppm_pkg::CountWidth-1:0]    out_hits_q;
  logic                              out_last_q;

  logic [SvcCh-1:0]                  en_w;
  logic [SvcCh-1:0]                  new_pend_w;
  logic [IdxW-1:0]                   top_idx_w;
  logic [STAMP_WIDTH-1:0]            old_w;
  logic [STAMP_WIDTH:0]              sub_w;
  logic                              gt_w;
  logic [STAMP_WIDTH-1:0]            diff_w;
  logic [ProdW-1:0]                  prod_w;
  logic                              req_acc_w;
  logic                              rsp_acc_w;

  assign req_acc_w = req_i.valid && req_i.ready;
  assign rsp_acc_w = rsp_o.valid && rsp_o.ready;

  // Channels allowed by the current mode.
  always_comb begin
    for (int i = 0; i < SvcCh; i++) begin
      en_w[i] = all_ch_q || (i >= Lowest);
    end
  end

  assign new_pend_w = req_i.edge_mask[SvcCh-1:0] & en_w;

  // Highest pending channel wins.
  always_comb begin
    top_idx_w = '0;
    for (int i = 0; i < SvcCh; i++) begin
      if (pend_q[i]) begin
        top_idx_w = IdxW'(i);
      end
    end
  end

  // Shared stamp subtractor; a non-positive difference wraps as new + ones - old.
  assign old_w  = stamp_mem_q[top_idx_w];
  assign sub_w  = {1'b0, stamp_q} - {1'b0, old_w};
  assign gt_w   = !sub_w[STAMP_WIDTH] && (sub_w[STAMP_WIDTH-1:0] != '0);
  assign diff_w = gt_w ? sub_w[STAMP_WIDTH-1:0]
                       : sub_w[STAMP_WIDTH-1:0] - STAMP_WIDTH'(1);

  // Shared period multiplier.
  assign prod_w = ProdW'(diff_q) * ProdW'(ns_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (req_acc_w) begin
          if (req_i.command == ppm_pkg::CmdOverflow || new_pend_w == '0) begin
            state_d = StOut;
          end else begin
            state_d = StDiff;
          end
        end
      end
      StDiff: state_d = StMul;
      StMul:  state_d = StOut;
      StOut: begin
        if (rsp_acc_w) begin
          state_d = out_last_q ? StIdle : StDiff;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      all_ch_q <= ppm_pkg::AllChannelsReset;
      ns_q     <= ppm_pkg::NsPerTickReset;
      pend_q   <= '0;
      total_q  <= '0;
      ovf_q    <= '0;
      for (int i = 0; i < SvcCh; i++) begin
        stamp_mem_q[i] <= '0;
        hits_mem_q[i]  <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i && cfg_idx_i == ppm_pkg::RegAllChannels) begin
        all_ch_q <= cfg_data_i[0];
      end
      if (cfg_we_i && cfg_idx_i == ppm_pkg::RegNsPerTick) begin
        ns_q <= cfg_data_i[ppm_pkg::NsWidth-1:0];
      end
      if (state_q == StIdle && req_acc_w) begin
        if (req_i.command == ppm_pkg::CmdOverflow) begin
          ovf_q  <= ovf_q + ppm_pkg::CountWidth'(1);
          pend_q <= '0;
        end else begin
          total_q <= total_q + ppm_pkg::CountWidth'(1);
          pend_q  <= new_pend_w;
        end
      end
      if (state_q == StDiff) begin
        stamp_mem_q[top_idx_w] <= stamp_q;
        hits_mem_q[top_idx_w]  <= hits_mem_q[top_idx_w] + ppm_pkg::CountWidth'(1);
        pend_q[top_idx_w]      <= 1'b0;
      end
    end
  end

  // Datapath registers; control above gates when they matter.
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && req_acc_w) begin
      stamp_q    <= req_i.timestamp[STAMP_WIDTH-1:0];
      out_cv_q   <= 1'b0;
      out_chan_q <= '0;
      out_per_q  <= '0;
      out_hits_q <= '0;
      out_last_q <= 1'b1;
    end
    if (state_q == StDiff) begin
      idx_q  <= top_idx_w;
      diff_q <= diff_w;
      hits_q <= hits_mem_q[top_idx_w] + ppm_pkg::CountWidth'(1);
    end
    if (state_q == StMul) begin
      out_cv_q   <= 1'b1;
      out_chan_q <= ppm_pkg::ChanWidth'(idx_q);
      out_per_q  <= ppm_pkg::PeriodWidth'(prod_w);
      out_hits_q <= hits_q;
      out_last_q <= (pend_q == '0);
    end
  end

  assign req_i.ready          = (state_q == StIdle);
  assign rsp_o.valid          = (state_q == StOut);
  assign rsp_o.channel_valid  = out_cv_q;
  assign rsp_o.channel        = out_chan_q;
  assign rsp_o.period_ns      = out_per_q;
  assign rsp_o.channel_hits   = out_hits_q;
  assign rsp_o.global_hits    = total_q;
  assign rsp_o.overflow_count = ovf_q;
  assign rsp_o.last           = out_last_q;

endmodule
`default_nettype wire

FILE: design/ppm_checker.sv
// Port-level checks for the pulse period meter, bound to the top level.
`default_nettype none
module ppm_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              req_ready_i,
  input wire logic                              rsp_valid_i,
  input wire logic                              rsp_ready_i,
  input wire logic                              rsp_channel_valid_i,
  input wire logic [ppm_pkg::ChanWidth-1:0]     rsp_channel_i,
  input wire logic [ppm_pkg::PeriodWidth-1:0]   rsp_period_ns_i,
  input wire logic                              rsp_last_i
);

  // One request at a time: never ready for a new one while a result is shown.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_ready_i && rsp_valid_i))
    else $error("request ready while a result is pending");

  // A status result always closes its request.
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_channel_valid_i) |-> rsp_last_i)
    else $error("status result without last");

  // Taking the final result frees the block for the next request.
  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && rsp_ready_i && rsp_last_i) |=> req_ready_i)
    else $error("not ready after final result");

  // Measured channels lie within the mask.
  a_chan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && rsp_channel_valid_i) |->
      (rsp_channel_i < ppm_pkg::ChanWidth'(ppm_pkg::MaskWidth)))
    else $error("channel number out of range");

  // A stalled result holds.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=>
      (rsp_valid_i && $stable(rsp_period_ns_i) && $stable(rsp_channel_i)))
    else $error("stalled result changed");

endmodule

bind multichannel_pulse_period_meter ppm_checker u_ppm_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .req_ready_i         (req_i.ready),
  .rsp_valid_i         (rsp_o.valid),
  .rsp_ready_i         (rsp_o.ready),
  .rsp_channel_valid_i (rsp_o.channel_valid),
  .rsp_channel_i       (rsp_o.channel),
  .rsp_period_ns_i     (rsp_o.period_ns),
  .rsp_last_i          (rsp_o.last)
);
`default_nettype wire

FILE: dv/ppm_period_checker.sv
// Watches the meter's channels, predicts each result and compares it with what comes out.
`default_nettype none
module ppm_period_checker import ppm_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [CfgIdxWidth-1:0]  cfg_idx_i,
  input  wire logic [CfgDataWidth-1:0] cfg_data_i,
  ppm_req_if                           req,
  ppm_rsp_if                           rsp,
  output int                           errors_o,
  output int                           pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumChannels = 10;
  localparam int LowestNarrow = NumChannels - NarrowChannels;
  localparam logic [TsWidth-1:0] StampOnes = '1;

  typedef struct packed {
    logic                   channel_valid;
    logic [ChanWidth-1:0]   channel;
    logic [PeriodWidth-1:0] period_ns;
    logic [CountWidth-1:0]  channel_hits;
    logic [CountWidth-1:0]  global_hits;
    logic [CountWidth-1:0]  overflow_count;
    logic                   last;
  } meter_result_t;

  meter_result_t expected_q[$];

  logic                  wide_mode;
  logic [NsWidth-1:0]    ns_scale;
  logic [TsWidth-1:0]    stamp_mem [NumChannels];
  logic [CountWidth-1:0] hits_mem  [NumChannels];
  logic [CountWidth-1:0] event_total;
  logic [CountWidth-1:0] overflow_total;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    errors_o++;
  endtask

  task automatic predict_periods(input logic cmd, input logic [MaskWidth-1:0] mask,
                                 input logic [TsWidth-1:0] stamp);
    meter_result_t r;
    int lowest;
    int served;
    logic [TsWidth-1:0] span;
    logic [63:0] product;
    served = 0;
    if (cmd == CmdOverflow) begin
      overflow_total++;
      r = '0;
      r.global_hits = event_total;
      r.overflow_count = overflow_total;
      r.last = 1'b1;
      expected_q.push_back(r);
    end else begin
      event_total++;
      lowest = wide_mode ? 0 : LowestNarrow;
      // highest channel goes first
      for (int ch = NumChannels - 1; ch >= lowest; ch--) begin
        if (mask[ch]) begin
          // equal or older stamps take the wrap branch
          if (stamp > stamp_mem[ch]) span = stamp - stamp_mem[ch];
          else span = stamp + (StampOnes - stamp_mem[ch]);
          product = 64'(span) * 64'(ns_scale);
          hits_mem[ch]++;
          stamp_mem[ch] = stamp;
          r = '0;
          r.channel_valid = 1'b1;
          r.channel = ChanWidth'(ch);
          r.period_ns = product[PeriodWidth-1:0];
          r.channel_hits = hits_mem[ch];
          r.global_hits = event_total;
          r.overflow_count = overflow_total;
          expected_q.push_back(r);
          served++;
        end
      end
      if (served == 0) begin
        r = '0;
        r.global_hits = event_total;
        r.overflow_count = overflow_total;
        r.last = 1'b1;
        expected_q.push_back(r);
      end else begin
        expected_q[$].last = 1'b1;
      end
    end
  endtask

  task automatic check_result();
    meter_result_t want;
    if (expected_q.size() == 0) begin
      report("result with nothing pending, channel", 64'(rsp.channel), 64'd0);
    end else begin
      want = expected_q.pop_front();
      if (rsp.channel_valid !== want.channel_valid)
        report("channel_valid", 64'(rsp.channel_valid), 64'(want.channel_valid));
      if (rsp.channel !== want.channel)
        report("channel", 64'(rsp.channel), 64'(want.channel));
      if (rsp.period_ns !== want.period_ns)
        report("period_ns", 64'(rsp.period_ns), 64'(want.period_ns));
      if (rsp.channel_hits !== want.channel_hits)
        report("channel_hits", 64'(rsp.channel_hits), 64'(want.channel_hits));
      if (rsp.global_hits !== want.global_hits)
        report("global_hits", 64'(rsp.global_hits), 64'(want.global_hits));
      if (rsp.overflow_count !== want.overflow_count)
        report("overflow_count", 64'(rsp.overflow_count), 64'(want.overflow_count));
      if (rsp.last !== want.last)
        report("last", 64'(rsp.last), 64'(want.last));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wide_mode = AllChannelsReset;
      ns_scale = NsPerTickReset;
      for (int i = 0; i < NumChannels; i++) begin
        stamp_mem[i] = '0;
        hits_mem[i] = '0;
      end
      event_total = '0;
      overflow_total = '0;
      expected_q.delete();
    end else begin
      // retire before predicting: a result never belongs to a request taken on the same edge
      if (rsp.valid && rsp.ready) check_result();
      if (req.valid && req.ready) predict_periods(req.command, req.edge_mask, req.timestamp);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegAllChannels: wide_mode = cfg_data_i[0];
          RegNsPerTick:   ns_scale = cfg_data_i;
          default: ;
        endcase
      end
    end
    pending_o = expected_q.size();
  end

endmodule
`default_nettype wire

FILE: dv/multichannel_pulse_period_meter_test.sv
// Stimulus and verdict for the pulse period meter, with the checker beside the block.
`default_nettype none
module multichannel_pulse_period_meter_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ppm_pkg::*;

  localparam int DrainCycles   = 40;
  localparam int HoldOffCycles = 400;
  localparam int PhaseItems    = 69;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we;
  logic [CfgIdxWidth-1:0]  cfg_idx;
  logic [CfgDataWidth-1:0] cfg_data;

  int check_errors;
  int pending;
  int burst_left;
  bit starve_output;
  logic [TsWidth-1:0] timer_now;

  ppm_req_if req_bus ();
  ppm_rsp_if rsp_bus ();

  multichannel_pulse_period_meter dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .req_i      (req_bus),
    .rsp_o      (rsp_bus)
  );

  ppm_period_checker meter_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .req        (req_bus),
    .rsp        (rsp_bus),
    .errors_o   (check_errors),
    .pending_o  (pending)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Offer one request and hold it until taken; idle between bursts.
  task automatic send_request(input logic cmd, input logic [MaskWidth-1:0] mask,
                              input logic [TsWidth-1:0] stamp);
    int gap;
    req_bus.valid     <= 1'b1;
    req_bus.command   <= cmd;
    req_bus.edge_mask <= mask;
    req_bus.timestamp <= stamp;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
    @(negedge clk_i);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      req_bus.valid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(negedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 6);
    end
  endtask

  // Drop valid and wait until every pending result is out and the block is idle.
  task automatic settle();
    req_bus.valid <= 1'b0;
    wait (pending == 0);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxWidth-1:0] idx, input logic [CfgDataWidth-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk_i);
    cfg_we   <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic random_event(output logic cmd, output logic [MaskWidth-1:0] mask,
                              output logic [TsWidth-1:0] stamp);
    int kind;
    cmd = ($urandom_range(0, 99) < 12) ? CmdOverflow : CmdEdge;
    kind = $urandom_range(0, 9);
    case (kind)
      0:       mask = '0;
      1:       mask = '1;
      2, 3:    mask = MaskWidth'(1) << $urandom_range(0, MaskWidth - 1);
      default: mask = MaskWidth'($urandom);
    endcase
    kind = $urandom_range(0, 9);
    case (kind)
      0: begin
        timer_now = $urandom;
        stamp = timer_now;
      end
      1:       stamp = $urandom_range(0, 1) ? '1 : '0;
      2:       stamp = timer_now;
      default: begin
        // advance the free-running timer, wrapping now and then
        timer_now = timer_now + $urandom_range(1, 5000);
        stamp = timer_now;
      end
    endcase
  endtask

  // Receiver: stall in patterns of its own, with one long hold-off on request.
  initial begin
    int stall_mode;
    int run;
    rsp_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall_mode = $urandom_range(0, 3);
      run = $urandom_range(8, 80);
      repeat (run) begin
        @(negedge clk_i);
        if (starve_output) begin
          starve_output = 1'b0;
          rsp_bus.ready <= 1'b0;
          repeat (HoldOffCycles) @(negedge clk_i);
        end
        case (stall_mode)
          0:       rsp_bus.ready <= 1'b1;
          1:       rsp_bus.ready <= 1'($urandom_range(0, 1));
          2:       rsp_bus.ready <= ($urandom_range(0, 3) == 0);
          default: rsp_bus.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  initial begin
    logic cmd;
    logic [MaskWidth-1:0] mask;
    logic [TsWidth-1:0] stamp;
    logic [CfgDataWidth-1:0] scale;
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    req_bus.valid = 1'b0;
    req_bus.command = CmdEdge;
    req_bus.edge_mask = '0;
    req_bus.timestamp = '0;
    burst_left = 0;
    starve_output = 1'b0;
    timer_now = 32'h0000_1000;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: all channels, 50 ns per tick
    send_request(CmdOverflow, 10'h000, 32'h0000_0000);
    send_request(CmdEdge, 10'h000, 32'h0000_1234);
    send_request(CmdEdge, 10'h3FF, 32'h0000_0000);   // equal stamps
    send_request(CmdEdge, 10'h3FF, 32'hFFFF_FFFF);
    send_request(CmdEdge, 10'h3FF, 32'h0000_0005);   // timer wrapped
    send_request(CmdEdge, 10'h001, 32'h0000_0010);
    send_request(CmdEdge, 10'h200, 32'h0000_0020);
    send_request(CmdEdge, 10'h155, 32'hAAAA_AAAA);
    send_request(CmdEdge, 10'h2AA, 32'h5555_5555);
    send_request(CmdOverflow, 10'h3FF, 32'hFFFF_FFFF);
    settle();

    // narrow mode at the largest scale
    write_reg(RegNsPerTick, 8'd255);
    write_reg(RegAllChannels, 8'd0);
    send_request(CmdEdge, 10'h01F, 32'h0001_0000);   // only excluded channels
    send_request(CmdEdge, 10'h3FF, 32'hFFFF_FFFF);
    send_request(CmdEdge, 10'h3E0, 32'h0000_0000);
    send_request(CmdEdge, 10'h021, 32'h1234_5678);
    send_request(CmdOverflow, 10'h000, 32'h0000_0000);
    settle();

    // zero scale
    write_reg(RegNsPerTick, 8'd0);
    send_request(CmdEdge, 10'h3FF, 32'h8765_4321);
    settle();

    write_reg(RegAllChannels, 8'd1);
    write_reg(RegNsPerTick, 8'd1);
    send_request(CmdEdge, 10'h3FF, 32'h8000_0000);
    send_request(CmdEdge, 10'h00F, 32'h7FFF_FFFF);
    send_request(CmdOverflow, 10'h000, 32'h0000_0000);
    settle();

    for (int p = 0; p < 5; p++) begin
      write_reg(RegAllChannels, (p == 0) ? 8'd0 : CfgDataWidth'($urandom_range(0, 1)));
      if (p == 1) scale = 8'd255;
      else if (p == 2) scale = 8'd1;
      else scale = CfgDataWidth'($urandom_range(1, 255));
      write_reg(RegNsPerTick, scale);
      if (p == 2) starve_output = 1'b1;
      for (int i = 0; i < PhaseItems; i++) begin
        random_event(cmd, mask, stamp);
        send_request(cmd, mask, stamp);
      end
      settle();
    end

    if (check_errors == 0 && pending == 0) begin
      $display("[multichannel_pulse_period_meter] OK");
    end else begin
      $display("[multichannel_pulse_period_meter] ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[multichannel_pulse_period_meter] ERROR");
    $finish;
  end

endmodule
`default_nettype wire

FILE: multichannel_pulse_period_meter.f
design/ppm_pkg.sv
design/ppm_if.sv
design/multichannel_pulse_period_meter.sv
design/ppm_checker.sv
dv/ppm_period_checker.sv
dv/multichannel_pulse_period_meter_test.sv
